@@ sv/gradient_noise_3d_assert.svh @@
// Assertion macros for the gradient noise block.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef GRADIENT_NOISE_3D_ASSERT_SVH
`define GRADIENT_NOISE_3D_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define GN3D_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check an implication in the cycle after its condition.
`define GN3D_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/gn3d_pkg.sv @@
// Shared constants, types and the gradient function of the gradient noise block.
// No dependencies.
package gn3d_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int HASH_W      = 11;
  localparam int COORD_W     = 32;
  localparam int OUT_W       = 18;
  localparam int M_W         = FRAC_BITS + 5;
  localparam int S_W         = M_W + 8;
  localparam int SH_R        = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_L        = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int OUT_MIN     = -131072;
  localparam int OUT_MAX     = 131071;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_BLEND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [HASH_W-1:0] data;
  } ram_wr_t;

  typedef logic [3:0] hash_t;

  function automatic logic signed [M_W-1:0] grad(
    input hash_t                 h,
    input logic signed [M_W-1:0] x,
    input logic signed [M_W-1:0] y,
    input logic signed [M_W-1:0] z
  );
    logic signed [M_W-1:0] u;
    logic signed [M_W-1:0] v;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      v = y;
    end else if (h inside {4'd12, 4'd14}) begin
      v = x;
    end else begin
      v = z;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

@@ sv/gradient_noise_3d.sv @@
// Top level of the 3D gradient noise block: input/output channels and sequencing.
// Depends on gn3d_pkg, gn3d_hash, gn3d_blend and gradient_noise_3d_assert.svh.
//
// Usage: one input channel (in_valid_i/in_ready_o) carries items; func_i = 0
// writes table_value_i into the 4096-entry hash table at table_index_i and gives
// no result; func_i = 1 evaluates noise at (coord_x_i, coord_y_i, coord_z_i),
// signed Q16.16, and gives one noise_value_o in signed Q2.16 on the output
// channel (out_valid_o/out_ready_i).
// An evaluate item runs paired table reads through the two read ports of the
// table RAM (three dependent levels), then 19 multiplies on one shared
// multiplier for the fades and the seven lerps.
// One item is in flight at a time; a new item is taken the cycle after the
// previous one has handed its result to the output register, so evaluate
// items never overlap.
// The output register holds a result until taken, so a stalled receiver
// holds the block only once a second result is ready.
// Reset clears the control state; the table is undefined until loaded and
// every entry an evaluation reaches must be loaded first.
module gradient_noise_3d (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [11:0]                          table_index_i,
  input  logic [10:0]                          table_value_i,
  input  logic signed [gn3d_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [gn3d_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [gn3d_pkg::COORD_W-1:0]  coord_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [gn3d_pkg::OUT_W-1:0]    noise_value_o
);
  import gn3d_pkg::*;
  `include "gradient_noise_3d_assert.svh"

  state_e  state_q, state_d;
  logic    in_fire, hash_start, hash_busy, hash_done, blend_start, blend_done;
  logic    out_free, out_load, out_valid_q, out_valid_d;
  ram_wr_t wr;
  hash_t   hashes [8];
  logic [HASH_W-1:0]    cx_q, cy_q, cz_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q, fz_q;
  logic signed [OUT_W-1:0] blend_res, noise_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign wr.en   = in_fire && (func_i == FUNC_LOAD)
                   && (32'(table_index_i) < TABLE_DEPTH);
  assign wr.addr = ADDR_W'(table_index_i);
  assign wr.data = table_value_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire && func_i == FUNC_EVAL) state_d = ST_HASH;
      ST_HASH:  if (hash_done) state_d = ST_BLEND;
      ST_BLEND: if (blend_done) state_d = out_free ? ST_IDLE : ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    hash_start  = 1'b0;
    blend_start = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE:  hash_start  = 1'b0;
      ST_HASH:  begin
        hash_start  = !hash_busy && !hash_done;
        blend_start = hash_done;
      end
      ST_BLEND: out_load = blend_done && out_free;
      ST_OUT:   out_load = out_free;
      default:  out_load = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Split each coordinate into a wrapped cell and its fraction.
  always_ff @(posedge clk_i) begin
    if (in_fire && func_i == FUNC_EVAL) begin
      cx_q <= HASH_W'(coord_x_i >>> FRAC_BITS);
      cy_q <= HASH_W'(coord_y_i >>> FRAC_BITS);
      cz_q <= HASH_W'(coord_z_i >>> FRAC_BITS);
      fx_q <= coord_x_i[FRAC_BITS-1:0];
      fy_q <= coord_y_i[FRAC_BITS-1:0];
      fz_q <= coord_z_i[FRAC_BITS-1:0];
    end
    if (out_load) begin
      noise_q <= blend_res;
    end
  end

  gn3d_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .start_i(hash_start),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .cz_i   (cz_q),
    .busy_o (hash_busy),
    .done_o (hash_done),
    .hash_o (hashes)
  );

  gn3d_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blend_start),
    .fx_i    (fx_q),
    .fy_i    (fy_q),
    .fz_i    (fz_q),
    .hash_i  (hashes),
    .done_o  (blend_done),
    .result_o(blend_res)
  );

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

  `GN3D_ASSERT_IMP(a_ready_no_hash, in_ready_o, !hash_busy, "input taken while hashing")
  `GN3D_ASSERT_IMP(a_hash_done_state, hash_done, state_q == ST_HASH, "stray hash done")
  `GN3D_ASSERT_IMP(a_blend_done_state, blend_done, state_q == ST_BLEND, "stray blend done")
  `GN3D_ASSERT_NEXT(a_out_wait_full, state_q == ST_OUT, out_valid_o, "result wait lost output")

endmodule

@@ sv/gn3d_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module gn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  output logic [WIDTH-1:0]         rd_data_a_o,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output logic [WIDTH-1:0]         rd_data_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem[rd_addr_a_i];
    rd_data_b_o <= mem[rd_addr_b_i];
  end

endmodule

@@ sv/gn3d_hash.sv @@
// Hash sequencer: holds the hash table and runs three levels of paired lookups.
// Depends on gn3d_pkg and gn3d_ram.
module gn3d_hash (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gn3d_pkg::ram_wr_t              wr_i,
  input  logic                           start_i,
  input  logic [gn3d_pkg::HASH_W-1:0]    cx_i,
  input  logic [gn3d_pkg::HASH_W-1:0]    cy_i,
  input  logic [gn3d_pkg::HASH_W-1:0]    cz_i,
  output logic                           busy_o,
  output logic                           done_o,
  output gn3d_pkg::hash_t                hash_o [8]
);
  import gn3d_pkg::*;

  logic              busy_q, busy_d, done_q, done_d;
  logic [2:0]        step_q, step_d;
  logic [ADDR_W-1:0] b_q, aa_q, ab_q, ba_q, bb_q;
  logic [ADDR_W-1:0] ra, rb, a_sum;
  logic [HASH_W-1:0] rd_a, rd_b;
  hash_t             h_q [8];

  gn3d_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_i.en),
    .wr_addr_i  (wr_i.addr),
    .wr_data_i  (wr_i.data),
    .rd_addr_a_i(ra),
    .rd_data_a_o(rd_a),
    .rd_addr_b_i(rb),
    .rd_data_b_o(rd_b)
  );

  assign a_sum = ADDR_W'(rd_a) + ADDR_W'(cy_i);

  // Issue the pair for this step; its data returns in the next step.
  always_comb begin
    case (step_q)
      3'd0:    ra = ADDR_W'(cx_i);
      3'd1:    ra = a_sum;
      3'd2:    ra = b_q;
      3'd3:    ra = aa_q;
      3'd4:    ra = ba_q;
      3'd5:    ra = ab_q;
      default: ra = bb_q;
    endcase
    rb = ra + ADDR_W'(1);
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = 3'd0;
      end
    end else begin
      step_d = step_q + 3'd1;
      if (step_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      case (step_q)
        3'd1: b_q <= ADDR_W'(rd_b) + ADDR_W'(cy_i);
        3'd2: begin
          aa_q <= ADDR_W'(rd_a) + ADDR_W'(cz_i);
          ab_q <= ADDR_W'(rd_b) + ADDR_W'(cz_i);
        end
        3'd3: begin
          ba_q <= ADDR_W'(rd_a) + ADDR_W'(cz_i);
          bb_q <= ADDR_W'(rd_b) + ADDR_W'(cz_i);
        end
        3'd4: begin
          h_q[0] <= rd_a[3:0];
          h_q[4] <= rd_b[3:0];
        end
        3'd5: begin
          h_q[1] <= rd_a[3:0];
          h_q[5] <= rd_b[3:0];
        end
        3'd6: begin
          h_q[2] <= rd_a[3:0];
          h_q[6] <= rd_b[3:0];
        end
        3'd7: begin
          h_q[3] <= rd_a[3:0];
          h_q[7] <= rd_b[3:0];
        end
        default: ;
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign hash_o = h_q;

endmodule

@@ sv/gn3d_blend.sv @@
// Blend unit: gradients, quintic fade and trilinear lerp on one shared multiplier.
// Depends on gn3d_pkg.
module gn3d_blend (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [gn3d_pkg::FRAC_BITS-1:0]      fx_i,
  input  logic [gn3d_pkg::FRAC_BITS-1:0]      fy_i,
  input  logic [gn3d_pkg::FRAC_BITS-1:0]      fz_i,
  input  gn3d_pkg::hash_t                     hash_i [8],
  output logic                                done_o,
  output logic signed [gn3d_pkg::OUT_W-1:0]   result_o
);
  import gn3d_pkg::*;

  localparam logic signed [M_W-1:0] One = M_W'(1) <<< FRAC_BITS;
  localparam logic [4:0] LastOp = 5'd18;

  logic                  busy_q, busy_d, phase_q, phase_d, done_q, done_d;
  logic [4:0]            op_q, op_d;
  logic signed [M_W-1:0] g_q [8];
  logic signed [M_W-1:0] lv_q [4];
  logic signed [M_W-1:0] fade_q [3];
  logic signed [M_W-1:0] inner_q, tt_q, p_q;
  logic signed [M_W-1:0] t [3];
  logic signed [M_W-1:0] x1, y1, z1, tcur, mul_a, mul_b;
  logic signed [2*M_W-1:0] prod;
  logic signed [OUT_W-1:0] res_q;
  logic signed [S_W-1:0]   r_s;
  logic [1:0]              ti;
  logic [1:0]              j;

  assign t[0] = M_W'(fx_i);
  assign t[1] = M_W'(fy_i);
  assign t[2] = M_W'(fz_i);
  assign x1 = t[0] - One;
  assign y1 = t[1] - One;
  assign z1 = t[2] - One;
  assign ti = op_q[3:2];
  assign j  = op_q[1:0];
  assign tcur = (ti == 2'd0) ? t[0] : ((ti == 2'd1) ? t[1] : t[2]);

  always_comb begin
    mul_a = tcur;
    mul_b = tcur;
    if (op_q < 5'd12) begin
      case (op_q[1:0])
        2'd0:    mul_b = M_W'(6 * tcur - 15 * One);
        2'd1:    mul_b = tcur;
        2'd2:    mul_a = tt_q;
        default: begin
          mul_a = tt_q;
          mul_b = inner_q;
        end
      endcase
    end else if (op_q < 5'd16) begin
      mul_a = fade_q[0];
      mul_b = g_q[{j, 1'b1}] - g_q[{j, 1'b0}];
    end else if (op_q < LastOp) begin
      mul_a = fade_q[1];
      mul_b = lv_q[{op_q[0], 1'b1}] - lv_q[{op_q[0], 1'b0}];
    end else begin
      mul_a = fade_q[2];
      mul_b = lv_q[1] - lv_q[0];
    end
  end

  assign prod = mul_a * mul_b;

  // Bring the final blend to 16 fraction bits.
  always_comb begin
    if (FRAC_BITS > 16) begin
      r_s = S_W'(lv_q[0] + p_q) >>> SH_R;
    end else begin
      r_s = S_W'(lv_q[0] + p_q) <<< SH_L;
    end
  end

  always_comb begin
    busy_d  = busy_q;
    op_d    = op_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d  = 1'b1;
        op_d    = 5'd0;
        phase_d = 1'b0;
      end
    end else begin
      phase_d = !phase_q;
      if (phase_q) begin
        op_d = op_q + 5'd1;
        if (op_q == LastOp) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      op_q    <= 5'd0;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      op_q    <= op_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      g_q[0] <= grad(hash_i[0], t[0], t[1], t[2]);
      g_q[1] <= grad(hash_i[1], x1,   t[1], t[2]);
      g_q[2] <= grad(hash_i[2], t[0], y1,   t[2]);
      g_q[3] <= grad(hash_i[3], x1,   y1,   t[2]);
      g_q[4] <= grad(hash_i[4], t[0], t[1], z1);
      g_q[5] <= grad(hash_i[5], x1,   t[1], z1);
      g_q[6] <= grad(hash_i[6], t[0], y1,   z1);
      g_q[7] <= grad(hash_i[7], x1,   y1,   z1);
    end else if (busy_q && !phase_q) begin
      p_q <= M_W'(prod >>> FRAC_BITS);
    end else if (busy_q) begin
      if (op_q < 5'd12) begin
        case (op_q[1:0])
          2'd0:    inner_q <= M_W'(p_q + 10 * One);
          2'd3:    fade_q[ti] <= p_q;
          default: tt_q <= p_q;
        endcase
      end else if (op_q < 5'd16) begin
        lv_q[j] <= g_q[{j, 1'b0}] + p_q;
      end else if (op_q < LastOp) begin
        lv_q[{1'b0, op_q[0]}] <= lv_q[{op_q[0], 1'b0}] + p_q;
      end else begin
        if (r_s < S_W'(OUT_MIN)) begin
          res_q <= OUT_W'(OUT_MIN);
        end else if (r_s > S_W'(OUT_MAX)) begin
          res_q <= OUT_W'(OUT_MAX);
        end else begin
          res_q <= OUT_W'(r_s);
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
